### hw/rtl/llfc_pkg.sv
// shared types, constants and helpers for the layered led fade compositor
package llfc_pkg;

	localparam int PIXELS        = 64;
	localparam int COLUMN_HEIGHT = 8;
	localparam int LAYERS        = 3;

	localparam int ENTRIES     = LAYERS * PIXELS;
	localparam int PIX_W       = $clog2(PIXELS);
	localparam int LAYER_W     = (LAYERS > 1) ? $clog2(LAYERS) : 1;
	localparam int ENT_W       = $clog2(ENTRIES);
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_W     = $clog2(QUEUE_DEPTH);
	localparam int PADDR_W     = 4;

	localparam logic [PIX_W-1:0]   PIX_LAST   = PIX_W'(PIXELS - 1);
	localparam logic [LAYER_W-1:0] LAYER_LAST = LAYER_W'(LAYERS - 1);

	localparam logic [7:0] FADE_STEP_RESET = 8'd20;
	localparam logic [7:0] SNAP_THR_RESET  = 8'd2;

	// [2] red, [1] green, [0] blue
	typedef logic [2:0][7:0] color_t;

	typedef enum logic [1:0] {
		CMD_WRITE       = 2'd0,
		CMD_CLEAR_LAYER = 2'd1,
		CMD_CLEAR_ALL   = 2'd2,
		CMD_TICK        = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		REG_FADE_ENABLE    = 2'd0,
		REG_FADE_STEP      = 2'd1,
		REG_SNAP_THRESHOLD = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} eng_state_t;

	typedef struct packed {
		logic [1:0] command;
		logic [1:0] layer;
		logic [3:0] x;
		logic [3:0] y;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} req_t;

	typedef struct packed {
		logic [5:0] pixel_index;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       last;
		logic       settled;
	} pix_t;

	typedef struct packed {
		cmd_code_t            kind;
		logic [LAYER_W-1:0]   layer;
		logic [PIX_W-1:0]     pix;
		color_t               color;
	} op_t;

	typedef struct packed {
		logic       fade_enable;
		logic [7:0] fade_step;
		logic [7:0] snap_threshold;
	} cfg_t;

	// serpentine column layout, odd columns run backwards, result clamped
	function automatic logic [PIX_W-1:0] map_xy(input logic [3:0] x, input logic [3:0] y);
		logic signed [9:0] off;
		logic signed [9:0] idx;
		logic [PIX_W-1:0]  res;
		if (x[0]) begin
			off = $signed(10'(COLUMN_HEIGHT - 1)) - $signed({6'b0, y});
		end else begin
			off = $signed({6'b0, y});
		end
		idx = $signed({6'b0, x}) * $signed(10'(COLUMN_HEIGHT)) + off;
		if (idx < 10'sd0) begin
			res = '0;
		end else if (idx > $signed(10'(PIXELS - 1))) begin
			res = PIX_LAST;
		end else begin
			res = idx[PIX_W-1:0];
		end
		return res;
	endfunction

endpackage

### hw/rtl/llfc_front.sv
// request decode: drops out-of-range layer ops and maps coordinates
module llfc_front import llfc_pkg::*; (
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic push_valid,
	input  logic push_ready,
	output op_t  push_op
);

	cmd_code_t kind;
	logic      layer_ok;
	logic      keep;

	always_comb begin
		kind     = cmd_code_t'(req.command);
		layer_ok = ({1'b0, req.layer} < 3'(LAYERS));
		unique case (kind)
			CMD_WRITE, CMD_CLEAR_LAYER: keep = layer_ok;
			CMD_CLEAR_ALL, CMD_TICK:    keep = 1'b1;
		endcase
	end

	always_comb begin
		push_op.kind  = kind;
		push_op.layer = req.layer[LAYER_W-1:0];
		push_op.pix   = map_xy(req.x, req.y);
		push_op.color = {req.red, req.green, req.blue};
	end

	assign req_ready  = push_ready;
	assign push_valid = req_valid && keep;

endmodule

### hw/rtl/llfc_queue.sv
// short op queue between decode and the engine
module llfc_queue import llfc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  op_t  push_op,
	output logic pop_valid,
	input  logic pop_ready,
	output op_t  pop_op
);

	op_t                slot_q [QUEUE_DEPTH];
	logic [QUEUE_W-1:0] wr_ptr_q;
	logic [QUEUE_W-1:0] rd_ptr_q;
	logic [QUEUE_W:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != (QUEUE_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_op     = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/llfc_engine.sv
// colour stores, fade scan pipeline and composite output
module llfc_engine import llfc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	input  op_t  q_op,
	input  cfg_t cfg,
	output logic pix_valid,
	input  logic pix_ready,
	output pix_t pix
);

	eng_state_t state_q, state_d;

	color_t goal_mem [ENTRIES];
	color_t cur_mem  [ENTRIES];
	color_t comp_mem [PIXELS];

	logic [ENTRIES-1:0] goal_vld_q;
	logic               cur_init_q;
	logic [ENTRIES-1:0] layer_mask;

	logic [LAYER_W-1:0] lay_q, lay_d;
	logic [PIX_W-1:0]   px_q, px_d;
	logic               scan_issue;
	logic               tick_start;
	logic               do_op;
	logic [ENT_W-1:0]   scan_addr;
	logic [ENT_W-1:0]   op_addr;

	logic               v_s1;
	logic [ENT_W-1:0]   addr_s1;
	logic [LAYER_W-1:0] lay_s1;
	logic [PIX_W-1:0]   px_s1;
	color_t             goal_raw_s1;
	color_t             cur_raw_s1;
	logic               goal_ok_s1;
	logic               cur_ok_s1;

	color_t             goal_c;
	color_t             cur_c;
	logic               eq_c;
	logic               near_c;
	logic [8:0]         kinv;
	logic [7:0]         diff;
	logic [2:0][16:0]   prod_a;
	logic [2:0][16:0]   prod_b;

	logic               v_s2;
	logic [ENT_W-1:0]   addr_s2;
	logic [LAYER_W-1:0] lay_s2;
	logic [PIX_W-1:0]   px_s2;
	color_t             goal_s2;
	color_t             cur_s2;
	logic               eq_s2;
	logic               near_s2;
	logic [2:0][16:0]   prod_a_s2;
	logic [2:0][16:0]   prod_b_s2;

	logic [16:0]        sum;
	color_t             blend;
	color_t             new_c;
	color_t             comp_base;
	color_t             comp_nxt;
	color_t             comp_q;
	logic               settled_q;

	logic [PIX_W-1:0]   emit_px_q;
	logic               emit_done_q;
	logic               emit_issue;
	logic               rdv_q;
	logic               load;
	logic [PIX_W-1:0]   rd_px_q;
	color_t             comp_rd_q;
	logic               pix_valid_q;
	pix_t               pix_q;

	// control
	always_comb begin
		state_d    = state_q;
		q_ready    = 1'b0;
		scan_issue = 1'b0;
		tick_start = 1'b0;
		lay_d      = lay_q;
		px_d       = px_q;
		unique case (state_q)
			ST_IDLE: begin
				q_ready = 1'b1;
				if (q_valid && q_op.kind == CMD_TICK) begin
					state_d    = ST_SCAN;
					tick_start = 1'b1;
					lay_d      = '0;
					px_d       = '0;
				end
			end
			ST_SCAN: begin
				scan_issue = 1'b1;
				if (lay_q == LAYER_LAST) begin
					lay_d = '0;
					if (px_q == PIX_LAST) begin
						state_d = ST_DRAIN;
						px_d    = '0;
					end else begin
						px_d = px_q + 1'b1;
					end
				end else begin
					lay_d = lay_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_done_q && !rdv_q) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lay_q   <= '0;
			px_q    <= '0;
		end else begin
			state_q <= state_d;
			lay_q   <= lay_d;
			px_q    <= px_d;
		end
	end

	// goal store updates
	assign do_op     = (state_q == ST_IDLE) && q_valid;
	assign op_addr   = ENT_W'(q_op.layer) * ENT_W'(PIXELS) + ENT_W'(q_op.pix);
	assign scan_addr = ENT_W'(lay_q) * ENT_W'(PIXELS) + ENT_W'(px_q);

	always_comb begin
		for (int l = 0; l < LAYERS; l++) begin
			layer_mask[l*PIXELS +: PIXELS] = {PIXELS{q_op.layer == LAYER_W'(l)}};
		end
	end

	always_ff @(posedge clk) begin
		if (do_op && q_op.kind == CMD_WRITE) begin
			goal_mem[op_addr] <= q_op.color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_vld_q <= '0;
		end else if (do_op) begin
			unique case (q_op.kind)
				CMD_WRITE:       goal_vld_q[op_addr] <= 1'b1;
				CMD_CLEAR_LAYER: goal_vld_q <= goal_vld_q & ~layer_mask;
				CMD_CLEAR_ALL:   goal_vld_q <= '0;
				CMD_TICK:        goal_vld_q <= goal_vld_q;
			endcase
		end
	end

	// scan stage 1: store reads
	always_ff @(posedge clk) begin
		if (scan_issue) begin
			goal_raw_s1 <= goal_mem[scan_addr];
			cur_raw_s1  <= cur_mem[scan_addr];
			goal_ok_s1  <= goal_vld_q[scan_addr];
			cur_ok_s1   <= cur_init_q;
			addr_s1     <= scan_addr;
			lay_s1      <= lay_q;
			px_s1       <= px_q;
		end
	end

	// unwritten entries read as black
	always_comb begin
		goal_c = goal_ok_s1 ? goal_raw_s1 : '0;
		cur_c  = cur_ok_s1 ? cur_raw_s1 : '0;
		eq_c   = (goal_c == cur_c);
		kinv   = 9'h100 - {1'b0, cfg.fade_step};
		near_c = 1'b1;
		diff   = '0;
		for (int c = 0; c < 3; c++) begin
			diff = (cur_c[c] > goal_c[c]) ? cur_c[c] - goal_c[c] : goal_c[c] - cur_c[c];
			if (diff > cfg.snap_threshold) begin
				near_c = 1'b0;
			end
			prod_a[c] = {9'b0, cur_c[c]} * {8'b0, kinv};
			prod_b[c] = {9'b0, goal_c[c]} * {9'b0, cfg.fade_step};
		end
	end

	// scan stage 2: products registered
	always_ff @(posedge clk) begin
		if (v_s1) begin
			goal_s2   <= goal_c;
			cur_s2    <= cur_c;
			eq_s2     <= eq_c;
			near_s2   <= near_c;
			prod_a_s2 <= prod_a;
			prod_b_s2 <= prod_b;
			addr_s2   <= addr_s1;
			lay_s2    <= lay_s1;
			px_s2     <= px_s1;
		end
	end

	always_comb begin
		sum = '0;
		for (int c = 0; c < 3; c++) begin
			sum      = prod_a_s2[c] + prod_b_s2[c];
			blend[c] = sum[15:8];
		end
		if (eq_s2) begin
			new_c = cur_s2;
		end else if (cfg.fade_enable && !near_s2) begin
			new_c = blend;
		end else begin
			new_c = goal_s2;
		end
		comp_base = (lay_s2 == '0) ? '0 : comp_q;
		comp_nxt  = (new_c != '0) ? new_c : comp_base;
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			cur_mem[addr_s2] <= new_c;
			comp_q           <= comp_nxt;
		end
		if (v_s2 && lay_s2 == LAYER_LAST) begin
			comp_mem[px_s2] <= comp_nxt;
		end
	end

	// the first tick rewrites every current colour, the last one at the final entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			cur_init_q <= 1'b0;
			settled_q  <= 1'b1;
		end else begin
			v_s1 <= scan_issue;
			v_s2 <= v_s1;
			if (v_s2 && addr_s2 == ENT_W'(ENTRIES - 1)) begin
				cur_init_q <= 1'b1;
			end
			if (tick_start) begin
				settled_q <= 1'b1;
			end else if (v_s2 && !eq_s2) begin
				settled_q <= 1'b0;
			end
		end
	end

	// composite output
	assign load       = rdv_q && (!pix_valid_q || pix_ready);
	assign emit_issue = (state_q == ST_EMIT) && !emit_done_q && (!rdv_q || load);

	always_ff @(posedge clk) begin
		if (emit_issue) begin
			comp_rd_q <= comp_mem[emit_px_q];
			rd_px_q   <= emit_px_q;
		end
		if (load) begin
			pix_q.pixel_index <= 6'(rd_px_q);
			pix_q.out_red     <= comp_rd_q[2];
			pix_q.out_green   <= comp_rd_q[1];
			pix_q.out_blue    <= comp_rd_q[0];
			pix_q.last        <= (rd_px_q == PIX_LAST);
			pix_q.settled     <= settled_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_px_q   <= '0;
			emit_done_q <= 1'b0;
			rdv_q       <= 1'b0;
			pix_valid_q <= 1'b0;
		end else begin
			if (tick_start) begin
				emit_px_q   <= '0;
				emit_done_q <= 1'b0;
			end else if (emit_issue) begin
				if (emit_px_q == PIX_LAST) begin
					emit_done_q <= 1'b1;
				end else begin
					emit_px_q <= emit_px_q + 1'b1;
				end
			end
			if (emit_issue) begin
				rdv_q <= 1'b1;
			end else if (load) begin
				rdv_q <= 1'b0;
			end
			if (load) begin
				pix_valid_q <= 1'b1;
			end else if (pix_ready) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

endmodule

### hw/rtl/layered_led_fade_compositor_top.sv
// top level: register port, request decode, op queue and fade engine
// write and clear requests are applied while the engine is idle; a tick scans all LAYERS*PIXELS entries,
// drains the scan pipeline, emits PIXELS composite pixels and returns to idle
// the first pixel is output only after the whole scan has drained
// reset: goal colours read as black through per-entry valid flags, current colours
// through one flag until the first tick has rewritten every entry, no clearing pass
module layered_led_fade_compositor_top import llfc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  req_t               req,
	output logic               pix_valid,
	input  logic               pix_ready,
	output pix_t               pix,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	op_t  push_op;
	logic pop_valid;
	logic pop_ready;
	op_t  pop_op;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fade_enable    <= 1'b1;
			cfg_q.fade_step      <= FADE_STEP_RESET;
			cfg_q.snap_threshold <= SNAP_THR_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_FADE_ENABLE:    cfg_q.fade_enable    <= pwdata[0];
				REG_FADE_STEP:      cfg_q.fade_step      <= pwdata[7:0];
				REG_SNAP_THRESHOLD: cfg_q.snap_threshold <= pwdata[7:0];
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_FADE_ENABLE:    prdata = {31'b0, cfg_q.fade_enable};
			REG_FADE_STEP:      prdata = {24'b0, cfg_q.fade_step};
			REG_SNAP_THRESHOLD: prdata = {24'b0, cfg_q.snap_threshold};
			default:            prdata = '0;
		endcase
	end

	llfc_front u_front (
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op)
	);

	llfc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_op     (pop_op)
	);

	llfc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (pop_valid),
		.q_ready   (pop_ready),
		.q_op      (pop_op),
		.cfg       (cfg_q),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

endmodule
